[design/rdfd_pkg.sv]
package rdfd_pkg;

    // Panel geometry default and fixed field widths
    localparam int PANEL_SIZE_DEF = 10;
    localparam int PIX_W          = 8;
    localparam int POS_W          = 8;
    localparam int ROW_W          = 4;
    localparam int WORD_W         = 30;
    localparam int SLOT_W         = 5;

    localparam logic [POS_W-1:0] POS_START = 8'd255;
    localparam logic [PIX_W-1:0] RICE_STEP = 8'd8;

    typedef enum logic {
        OP_KEY    = 1'b0,
        OP_STREAM = 1'b1
    } rdfd_op_t;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] key_slot;
        logic [7:0]        key_byte;
        logic              stream_bit;
    } rdfd_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  row_number;
        logic [WORD_W-1:0] row_bits;
        logic              position_error;
        logic              last;
    } rdfd_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY,
        ST_EVT,
        ST_UPD,
        ST_FRD,
        ST_FACC,
        ST_FOUT
    } rdfd_state_t;

endpackage

[design/rice_delta_frame_decoder.sv]
// Keyframe byte: accepted in ST_IDLE, then four pixel writes in ST_KEY (pixels past the
// panel skipped). Stream bit: accepted in ST_IDLE; a bit that closes a nonzero event adds
// the position step (ST_EVT) and, if that lands on the panel, the pixel read-modify-write
// (ST_UPD). Frame end: PANEL_SIZE+1 words, each from PANEL_SIZE registered pixel reads
// (ST_FRD then ST_FACC), sent from ST_FOUT once the output is free. Reset (rst_n low,
// async) zeroes the pixel store through per-pixel valid bits, so no clearing pass is
// needed; stream state returns to position 255, event 0, no error.
module rice_delta_frame_decoder #(
    parameter int PANEL_SIZE = rdfd_pkg::PANEL_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rdfd_pkg::rdfd_in_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output rdfd_pkg::rdfd_out_t out_data
);

    import rdfd_pkg::*;

    localparam int PIXEL_COUNT = PANEL_SIZE * PANEL_SIZE;
    localparam int ADDR_W      = $clog2(PIXEL_COUNT);
    localparam int IDX_W       = SLOT_W + 2;
    localparam int ROW_BITS    = 3 * (PANEL_SIZE - 1);
    localparam int DIAG_BITS   = 3 * PANEL_SIZE;

    localparam logic [ROW_W-1:0]  LAST_COL  = ROW_W'(PANEL_SIZE - 1);
    localparam logic [ROW_W-1:0]  DIAG_ROW  = ROW_W'(PANEL_SIZE);
    localparam logic [ADDR_W-1:0] DIAG_STEP = ADDR_W'(PANEL_SIZE + 1);

    // Sequencer and stream state
    rdfd_state_t       state_reg,  state_next;
    logic [1:0]        suffix_reg, suffix_next;
    logic [PIX_W-1:0]  event_reg,  event_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic              error_reg,  error_next;
    logic [PIXEL_COUNT-1:0] valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;

    // Working registers (no reset)
    logic [SLOT_W-1:0] slot_reg,   slot_next;
    logic [7:0]        byte_reg,   byte_next;
    logic [1:0]        lane_reg,   lane_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [ROW_W-1:0]  col_reg,    col_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic              parity_reg, parity_next;
    logic              rd_valid_reg, rd_valid_next;
    logic [PANEL_SIZE-1:0] plane0_reg, plane0_next;
    logic [PANEL_SIZE-1:0] plane1_reg, plane1_next;
    logic [PANEL_SIZE-1:0] plane2_reg, plane2_next;
    rdfd_out_t         out_data_reg, out_data_next;

    // Pixel store port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [PIX_W-1:0]  ram_rdata;

    // Helpers
    logic [PIX_W-1:0]  px;
    logic [POS_W-1:0]  pos_sum;
    logic [IDX_W-1:0]  key_idx;
    logic [PIX_W-1:0]  suffix_add;
    logic              plane_shift;
    logic              out_free;
    logic [WORD_W-1:0] word;

    rdfd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Unwritten pixels read as zero
    assign px          = rd_valid_reg ? ram_rdata : '0;
    assign pos_sum     = pos_reg + {1'b0, event_reg[PIX_W-1:1]};
    assign key_idx     = {slot_reg, 2'b00} + IDX_W'(lane_reg);
    assign suffix_add  = PIX_W'(in_data.stream_bit) << (suffix_reg - 2'd1);
    assign plane_shift = (row_reg == DIAG_ROW) || (col_reg != row_reg);
    assign out_free    = !out_valid_reg || out_ready;

    // Frame word from the three thermometer planes; first column sits lowest
    always_comb
    begin
        word = '0;
        if (row_reg == DIAG_ROW)
        begin
            word[DIAG_BITS-1:0] = {plane2_reg, plane1_reg, plane0_reg};
        end
        else
        begin
            word[ROW_BITS-1:0] = {plane2_reg[PANEL_SIZE-1:1], plane1_reg[PANEL_SIZE-1:1],
                                  plane0_reg[PANEL_SIZE-1:1]};
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        suffix_next    = suffix_reg;
        event_next     = event_reg;
        pos_next       = pos_reg;
        error_next     = error_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        slot_next      = slot_reg;
        byte_next      = byte_reg;
        lane_next      = lane_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        addr_next      = addr_reg;
        parity_next    = parity_reg;
        rd_valid_next  = rd_valid_reg;
        plane0_next    = plane0_reg;
        plane1_next    = plane1_reg;
        plane2_next    = plane2_reg;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg[ADDR_W-1:0];
        ram_wdata      = '0;
        ram_raddr      = addr_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_data.operation == OP_KEY)
                    begin
                        slot_next   = in_data.key_slot;
                        byte_next   = in_data.key_byte;
                        lane_next   = '0;
                        suffix_next = '0;
                        event_next  = '0;
                        pos_next    = POS_START;
                        error_next  = 1'b0;
                        state_next  = ST_KEY;
                    end
                    else if (suffix_reg == 2'd0)
                    begin
                        // unary prefix: zero adds 8, one opens the 3-bit suffix
                        if (in_data.stream_bit)
                        begin
                            suffix_next = 2'd3;
                        end
                        else
                        begin
                            event_next = event_reg + RICE_STEP;
                        end
                    end
                    else
                    begin
                        suffix_next = suffix_reg - 2'd1;
                        event_next  = event_reg + suffix_add;
                        if (suffix_reg == 2'd1)
                        begin
                            state_next = ST_EVT;
                        end
                    end
                end
            end

            ST_KEY:
            begin
                if (key_idx < IDX_W'(PIXEL_COUNT))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = key_idx[ADDR_W-1:0];
                    ram_wdata = PIX_W'(byte_reg[2*lane_reg +: 2]);
                    valid_next[key_idx[ADDR_W-1:0]] = 1'b1;
                end
                lane_next = lane_reg + 2'd1;
                if (lane_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_EVT:
            begin
                if (event_reg == '0)
                begin
                    // end of frame: start the row sweep
                    row_next    = '0;
                    col_next    = '0;
                    addr_next   = '0;
                    plane0_next = '0;
                    plane1_next = '0;
                    plane2_next = '0;
                    state_next  = ST_FRD;
                end
                else
                begin
                    pos_next    = pos_sum;
                    event_next  = '0;
                    parity_next = event_reg[0];
                    if (pos_sum < POS_W'(PIXEL_COUNT))
                    begin
                        ram_raddr     = pos_sum[ADDR_W-1:0];
                        rd_valid_next = valid_reg[pos_sum[ADDR_W-1:0]];
                        state_next    = ST_UPD;
                    end
                    else
                    begin
                        error_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_UPD:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg[ADDR_W-1:0];
                ram_wdata = parity_reg ? px + PIX_W'(1) : px - PIX_W'(1);
                valid_next[pos_reg[ADDR_W-1:0]] = 1'b1;
                state_next = ST_IDLE;
            end

            ST_FRD:
            begin
                ram_raddr     = addr_reg;
                rd_valid_next = valid_reg[addr_reg];
                state_next    = ST_FACC;
            end

            ST_FACC:
            begin
                if (plane_shift)
                begin
                    plane0_next = {px > PIX_W'(0), plane0_reg[PANEL_SIZE-1:1]};
                    plane1_next = {px > PIX_W'(1), plane1_reg[PANEL_SIZE-1:1]};
                    plane2_next = {px > PIX_W'(2), plane2_reg[PANEL_SIZE-1:1]};
                end
                if (col_reg == LAST_COL)
                begin
                    // rows end on the pixel before the next row; the diagonal restarts at 0
                    addr_next  = (row_reg == LAST_COL || row_reg == DIAG_ROW) ? '0
                                                                            : addr_reg + 1'b1;
                    state_next = ST_FOUT;
                end
                else
                begin
                    col_next   = col_reg + 1'b1;
                    addr_next  = (row_reg == DIAG_ROW) ? addr_reg + DIAG_STEP
                                                        : addr_reg + 1'b1;
                    state_next = ST_FRD;
                end
            end

            ST_FOUT:
            begin
                if (out_free)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.row_number     = row_reg;
                    out_data_next.row_bits       = word;
                    out_data_next.position_error = error_reg;
                    out_data_next.last           = (row_reg == DIAG_ROW);
                    plane0_next = '0;
                    plane1_next = '0;
                    plane2_next = '0;
                    col_next    = '0;
                    row_next    = row_reg + 1'b1;
                    if (row_reg == DIAG_ROW)
                    begin
                        pos_next   = POS_START;
                        event_next = '0;
                        error_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FRD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            suffix_reg    <= '0;
            event_reg     <= '0;
            pos_reg       <= POS_START;
            error_reg     <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            suffix_reg    <= suffix_next;
            event_reg     <= event_next;
            pos_reg       <= pos_next;
            error_reg     <= error_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        byte_reg     <= byte_next;
        lane_reg     <= lane_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        addr_reg     <= addr_next;
        parity_reg   <= parity_next;
        rd_valid_reg <= rd_valid_next;
        plane0_reg   <= plane0_next;
        plane1_reg   <= plane1_next;
        plane2_reg   <= plane2_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[design/rdfd_ram.sv]
module rdfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 100
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[sim/rdfd_frame_checker.sv]
module rdfd_frame_checker #(
    parameter int PANEL = rdfd_pkg::PANEL_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  rdfd_pkg::rdfd_in_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  rdfd_pkg::rdfd_out_t out_data,
    output int                  fail_count,
    output int                  due_words,
    output int                  items_seen,
    output int                  words_seen,
    output int                  frames_seen,
    output int                  flagged_frames
);

    import rdfd_pkg::*;

    localparam int CELLS      = PANEL * PANEL;

    // shadow decoder state
    logic [PIX_W-1:0] pix [CELLS];
    logic [1:0]       suffix_left;
    logic [PIX_W-1:0] evt_sum;
    logic [POS_W-1:0] cur_pos;
    logic             pos_err;

    rdfd_out_t rows_due [$];

    int mismatches = 0;
    int items_n    = 0;
    int words_n    = 0;
    int frames_n   = 0;
    int flagged_n  = 0;

    function automatic logic [WORD_W-1:0] level_planes(logic [PIX_W-1:0] px, int col,
                                                       int stride);
        logic [WORD_W-1:0] w;
        w = '0;
        if (px > 0) w[col] = 1'b1;
        if (px > 1) w[col + stride] = 1'b1;
        if (px > 2) w[col + 2 * stride] = 1'b1;
        return w;
    endfunction

    task automatic restart_stream();
        suffix_left = 2'd0;
        evt_sum     = '0;
        cur_pos     = POS_START;
        pos_err     = 1'b0;
    endtask

    // PANEL row words (diagonal skipped), then the diagonal word
    task automatic queue_frame();
        rdfd_out_t         w;
        logic [WORD_W-1:0] bits;
        for (int r = 0; r < PANEL; r++)
        begin
            bits = '0;
            for (int c = 0; c < PANEL; c++)
            begin
                if (c != r)
                    bits |= level_planes(pix[r * PANEL + c], (c > r) ? c - 1 : c, PANEL - 1);
            end
            w.row_number     = ROW_W'(r);
            w.row_bits       = bits;
            w.position_error = pos_err;
            w.last           = 1'b0;
            rows_due.push_back(w);
        end
        bits = '0;
        for (int r = 0; r < PANEL; r++)
            bits |= level_planes(pix[r * PANEL + r], r, PANEL);
        w.row_number     = ROW_W'(PANEL);
        w.row_bits       = bits;
        w.position_error = pos_err;
        w.last           = 1'b1;
        rows_due.push_back(w);
        frames_n++;
        if (pos_err)
            flagged_n++;
    endtask

    task automatic advance_decoder(input rdfd_in_t it);
        int idx;
        if (it.operation == OP_KEY)
        begin
            for (int j = 0; j < 4; j++)
            begin
                idx = int'(it.key_slot) * 4 + j;
                if (idx < CELLS)
                    pix[idx] = {6'd0, it.key_byte[2 * j +: 2]};
            end
            restart_stream();
        end
        else if (suffix_left == 2'd0)
        begin
            // unary prefix: zero adds a step, one opens the 3-bit suffix
            if (!it.stream_bit)
                evt_sum = evt_sum + RICE_STEP;
            else
                suffix_left = 2'd3;
        end
        else
        begin
            suffix_left = suffix_left - 2'd1;
            evt_sum     = evt_sum + ({7'd0, it.stream_bit} << suffix_left);
            if (suffix_left == 2'd0)
            begin
                if (evt_sum == '0)
                begin
                    queue_frame();
                    restart_stream();
                end
                else
                begin
                    cur_pos = cur_pos + (evt_sum >> 1);
                    if (cur_pos < CELLS)
                    begin
                        if (evt_sum[0])
                            pix[cur_pos] = pix[cur_pos] + 8'd1;
                        else
                            pix[cur_pos] = pix[cur_pos] - 8'd1;
                    end
                    else
                        pos_err = 1'b1;
                    evt_sum = '0;
                end
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t checker: %s", $time, msg);
    endtask

    task automatic check_word(input rdfd_out_t got);
        rdfd_out_t want;
        words_n++;
        if (rows_due.size() == 0)
            report_mismatch($sformatf("unexpected word, row %0d bits %h",
                                      got.row_number, got.row_bits));
        else
        begin
            want = rows_due.pop_front();
            if (got.row_number != want.row_number)
                report_mismatch($sformatf("row_number %0d, want %0d",
                                          got.row_number, want.row_number));
            if (got.row_bits != want.row_bits)
                report_mismatch($sformatf("row %0d: row_bits %h, want %h",
                                          want.row_number, got.row_bits, want.row_bits));
            if (got.position_error != want.position_error)
                report_mismatch($sformatf("row %0d: position_error %b, want %b",
                                          want.row_number, got.position_error,
                                          want.position_error));
            if (got.last != want.last)
                report_mismatch($sformatf("row %0d: last %b, want %b",
                                          want.row_number, got.last, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                pix[i] = '0;
            restart_stream();
            rows_due.delete();
            due_words <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            // predict first so a word can never race its own item
            if (in_valid && in_ready)
            begin
                items_n++;
                advance_decoder(in_data);
            end
            if (out_valid && out_ready)
                check_word(out_data);
            due_words      <= rows_due.size();
            fail_count     <= mismatches;
            items_seen     <= items_n;
            words_seen     <= words_n;
            frames_seen    <= frames_n;
            flagged_frames <= flagged_n;
        end
    end

endmodule

[sim/tb_top.sv]
module tb_top;
    import rdfd_pkg::*;

    localparam int PANEL         = PANEL_SIZE_DEF;
    localparam int HOLD_CYCLES   = 600;   // long output back-pressure stretch
    localparam int QUIET_LIMIT   = 4000;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 40;    // covers keyframe writes and stream tail
    localparam int RANDOM_ITEMS  = 110;   // wrap frame plus random mix

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    rdfd_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    rdfd_out_t out_data;

    int fail_count;
    int due_words;
    int items_seen;
    int words_seen;
    int frames_seen;
    int flagged_frames;

    int   quiet_cycles = 0;
    int   sent_items   = 0;
    logic steady_send  = 1'b0;   // sender burst mode: no gaps
    logic steady_recv  = 1'b0;   // receiver burst mode: no stalls
    logic hold_req     = 1'b0;   // asks the receiver for one long hold-off

    rice_delta_frame_decoder #(
        .PANEL_SIZE (PANEL)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Checker watches both channels, runs its own decoder and compares words.
    rdfd_frame_checker #(
        .PANEL (PANEL)
    ) frame_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .due_words      (due_words),
        .items_seen     (items_seen),
        .words_seen     (words_seen),
        .frames_seen    (frames_seen),
        .flagged_frames (flagged_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Sender side. Every item gets a randomly drawn gap unless the sender
    // is in a burst. Valid is only dropped when a real gap follows, so
    // back-to-back items keep valid high with one assignment per edge.
    // ------------------------------------------------------------------
    task automatic offer_item(input rdfd_in_t it);
        int gap;
        gap = steady_send ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_items++;
    endtask

    // stream bit; key fields carry junk the block must ignore
    task automatic send_bit(input logic b);
        rdfd_in_t it;
        it.operation  = OP_STREAM;
        it.key_slot   = SLOT_W'($urandom);
        it.key_byte   = 8'($urandom);
        it.stream_bit = b;
        offer_item(it);
    endtask

    // keyframe byte; stream_bit is junk here
    task automatic send_key(input int slot, input int value);
        rdfd_in_t it;
        it.operation  = OP_KEY;
        it.key_slot   = SLOT_W'(slot);
        it.key_byte   = 8'(value);
        it.stream_bit = 1'($urandom);
        offer_item(it);
    endtask

    // Rice k=3 code: value/8 zeros, a one, then 3 suffix bits MSB first.
    // Value 0 ends the frame; 256 wraps the 8-bit sum to zero as well.
    task automatic send_event(input int value);
        repeat (value / 8) send_bit(1'b0);
        send_bit(1'b1);
        for (int i = 2; i >= 0; i--)
            send_bit(1'((value >> i) & 1));
    endtask

    // drop valid, wait until every predicted word is out, let the block go idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_words != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side, its own process. Stalls for a random draw before each
    // word, with burst stretches, and once holds ready low for HOLD_CYCLES so
    // the frame output backs up and the input stalls.
    // ------------------------------------------------------------------
    initial
    begin : sink
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 7) == 0)
                    steady_recv = !steady_recv;
                stall = steady_recv ? 0 : $urandom_range(0, 11);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Watchdog: a long run of cycles with no handshake on either side
    // means the block hung or words went missing.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d words still due",
                     QUIET_LIMIT, due_words);
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int pick;
        int random_base;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        // slot past the panel: nothing may be written
        send_key(31, 8'h5A);
        // all-ones and all-zeros keyframe bytes at both ends of the store
        send_key(0, 8'hFF);
        send_key(24, 8'h00);
        // event 1: no step from position 255, so the update is out of range
        send_event(1);
        // event 3: wraps position to 0, odd -> pixel 0 goes 3 -> 4
        send_event(3);
        // event 10: one prefix zero, step 5, even -> pixel 5 wraps 0 -> 255
        send_event(10);
        // zero event closes the frame with the error flag still set
        send_event(0);
        settle();

        // --- random part ---
        random_base = sent_items;
        // Long output hold over a frame closed by an event whose 8-bit sum
        // wraps to zero; the sender keeps offering items behind it.
        hold_req = 1'b1;
        send_event(256);
        while (sent_items - random_base < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
                steady_send = !steady_send;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_event($urandom_range(1, 24));      // short steps across the panel
            else if (pick < 56)
                send_event($urandom_range(25, 255));    // long steps, mostly off panel
            else if (pick < 70)
                send_event(0);                          // frame end
            else if (pick < 84)
                send_key($urandom_range(0, 31), $urandom_range(0, 255));
            else
                send_bit(1'($urandom_range(0, 1)));     // noise: shifts code alignment
        end
        settle();

        $display("covered %0d items in, %0d words out over %0d frames (%0d with error flag)",
                 items_seen, words_seen, frames_seen, flagged_frames);
        $display("including keyframe loads past the panel, wrapped events and a %0d-cycle hold",
                 HOLD_CYCLES);
        if (fail_count == 0 && due_words == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

[files.f]
design/rdfd_pkg.sv
design/rdfd_ram.sv
design/rice_delta_frame_decoder.sv
sim/rdfd_frame_checker.sv
sim/tb_top.sv
